FILE: design/ilb_pkg.sv
// ilb_pkg: shared constants and types for the integer literal parser
// used by ilb_char_decode, ilb_parse_core and integer_literal_to_binary_unit
package ilb_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAG_W      = VALUE_BITS;
  localparam int EXT_W      = VALUE_BITS + 4;
  localparam int RES_W      = 32;
  localparam int NEG_W      = (VALUE_BITS >= RES_W) ? VALUE_BITS : RES_W;

  localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_O  = 8'h6f;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  typedef struct packed {
    logic [3:0] digit;
    logic       is_minus;
    logic       is_zero;
    logic       is_b;
    logic       is_o;
    logic       is_x;
  } chr_info_t;

endpackage

FILE: design/ilb_char_decode.sv
// ilb_char_decode: classifies one ascii character and gives its digit value
// depends on ilb_pkg
module ilb_char_decode (
  input  logic [7:0]         chr,
  output ilb_pkg::chr_info_t info
);
  import ilb_pkg::*;

  logic [7:0] off;

  always_comb begin
    off = 8'd0;
    info = '0;
    if (chr >= CH_ZERO && chr <= CH_NINE) begin
      off = chr - CH_ZERO;
      info.digit = off[3:0];
    end else if (chr >= CH_LO_A && chr <= CH_LO_F) begin
      off = chr - CH_LO_A + 8'd10;
      info.digit = off[3:0];
    end else if (chr >= CH_UP_A && chr <= CH_UP_F) begin
      off = chr - CH_UP_A + 8'd10;
      info.digit = off[3:0];
    end
    info.is_minus = (chr == CH_MINUS);
    info.is_zero  = (chr == CH_ZERO);
    info.is_b     = (chr == CH_LO_B);
    info.is_o     = (chr == CH_LO_O);
    info.is_x     = (chr == CH_LO_X);
  end

endmodule

FILE: design/ilb_parse_core.sv
// ilb_parse_core: parse state, magnitude accumulation and result forming
// depends on ilb_pkg
module ilb_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  ilb_pkg::chr_info_t info,
  input  logic               last_char,
  output logic [31:0]        res_value,
  output logic               res_oor
);
  import ilb_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_BIN = 2'd1,
    RX_OCT = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             ovf_r, ovf_nxt;
  logic             do_acc;
  logic [EXT_W-1:0] ext, prod, sum;
  logic [MAG_W-1:0] lim_sel;
  logic [NEG_W-1:0] signed_val;

  always_comb begin
    ext = EXT_W'(mag_r);
    case (radix_r)
      RX_DEC:  prod = (ext << 3) + (ext << 1);
      RX_BIN:  prod = ext << 1;
      RX_OCT:  prod = ext << 3;
      RX_HEX:  prod = ext << 4;
      default: prod = ext;
    endcase
    sum = prod + EXT_W'(info.digit);
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    do_acc    = 1'b0;
    case (phase_r)
      PH_START, PH_SIGN: begin
        if (phase_r == PH_START && info.is_minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGN;
        end else if (info.is_zero) begin
          phase_nxt = PH_ZERO;
        end else begin
          do_acc    = 1'b1;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (info.is_b) begin
          radix_nxt = RX_BIN;
        end else if (info.is_o) begin
          radix_nxt = RX_OCT;
        end else if (info.is_x) begin
          radix_nxt = RX_HEX;
        end else begin
          do_acc = 1'b1;
        end
        phase_nxt = PH_DIGITS;
      end
      default: begin
        do_acc = 1'b1;
      end
    endcase

    mag_nxt = mag_r;
    ovf_nxt = ovf_r;
    if (do_acc && !ovf_r) begin
      if (sum > EXT_W'(MAG_LIMIT)) begin
        ovf_nxt = 1'b1;
      end else begin
        mag_nxt = sum[MAG_W-1:0];
      end
    end

    lim_sel    = neg_nxt ? MAG_LIMIT : MAG_LIMIT - MAG_W'(1);
    res_oor    = ovf_nxt || (mag_nxt > lim_sel);
    signed_val = neg_nxt ? (NEG_W'(0) - NEG_W'(mag_nxt)) : NEG_W'(mag_nxt);
    res_value  = res_oor ? 32'd0 : signed_val[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RX_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step_en) begin
      if (last_char) begin
        phase_r <= PH_START;
        radix_r <= RX_DEC;
        neg_r   <= 1'b0;
        mag_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        neg_r   <= neg_nxt;
        mag_r   <= mag_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= MAG_LIMIT)
    else $error("magnitude above limit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last_char |=> phase_r == PH_START && mag_r == '0 && !ovf_r && !neg_r)
    else $error("state not cleared after last item");

  a_ovf_holds_mag: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && step_en && !last_char |=> $stable(mag_r) && ovf_r)
    else $error("magnitude moved after overflow");

  a_radix_phase: assert property (@(posedge clk) disable iff (!rst_n)
    radix_r != RX_DEC |-> phase_r == PH_DIGITS)
    else $error("prefix radix outside digit phase");

  a_neg_phase: assert property (@(posedge clk) disable iff (!rst_n)
    neg_r |-> phase_r != PH_START)
    else $error("sign set at start of literal");
`endif

endmodule

FILE: design/integer_literal_to_binary_unit.sv
// integer_literal_to_binary_unit: top level of the ascii integer literal parser
// depends on ilb_pkg, ilb_char_decode and ilb_parse_core
//
// input channel: one character per item (in_character, in_last_char), with
// in_valid / in_ready. a literal is an optional '-', an optional lowercase
// 0b / 0o / 0x prefix and digits; hex letters in either case
// result channel: one item per literal, given for the item with in_last_char
// set: out_value (signed 32 bits) and out_out_of_range, with out_valid /
// out_ready. an out-of-range literal gives zero with the flag set
// the last character is held in the input register, its result in the output register
// throughput: one character per cycle unless stalled, set by the combinational
// multiply-accumulate and limit compare in the parse core
// the input register takes a new item while a result waits in the output
// register; a stalled receiver holds back only a last character
// reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a literal, decimal, positive, zero magnitude
module integer_literal_to_binary_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        out_out_of_range
);
  import ilb_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        out_oor_r;
  logic        out_free;
  logic        s1_go;
  logic        in_acc;
  chr_info_t   info;
  logic [31:0] res_value;
  logic        res_oor;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  ilb_char_decode u_decode (
    .chr  (s1_char_r),
    .info (info)
  );

  ilb_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .info      (info),
    .last_char (s1_last_r),
    .res_value (res_value),
    .res_oor   (res_oor)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last_char;
    end
    if (s1_go && s1_last_r) begin
      out_value_r <= res_value;
      out_oor_r   <= res_oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_out_of_range = out_oor_r;

endmodule
